// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and constants of the sequential list engine
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;
  localparam int FPOS_W       = 6;
  localparam int DEF_CAPACITY = 64;
  localparam int MAX_CAPACITY = 1024;
  // wide enough for any count or position the block can see
  localparam int CMP_W        = $clog2(MAX_CAPACITY + 1);
  // match bits examined per search cycle
  localparam int GRP_SIZE     = 8;
  localparam int GSEL_W       = $clog2(GRP_SIZE);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              clr;
    logic [DATA_W-1:0] value;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
  } cell_ctrl_t;

endpackage

// ===== rtl/sequential_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// ordered list of signed 32-bit values kept in a row of cells
// timing: insert, delete and clear give their result in the cycle after the
//   transaction; locate first searches the snapshot of the match bits, eight
//   bits per cycle, and gives its result at the first hit or the last group
// throughput: one transaction at a time; the next is taken once the result
//   register is free and the search has finished
// reset: synchronous rst empties the list and clears the control; entry
//   contents are not reset
// ----------------------------------------------------------------------------
module sequential_list_engine_core import sle_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic                     found,
  output logic [FPOS_W-1:0]        found_position,
  output logic [LEN_W-1:0]         length,
  output logic                     is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW  = NGRP * GRP_SIZE;

  // control registers
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [GW-1:0]    grp, grp_next;
  // snapshot of the match bits for the search
  logic [PADW-1:0]  hit_vec;

  // cell row
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0] match_bits;

  logic       in_fire;
  logic       out_free;
  op_t        op;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic       ins_ok;
  logic       del_ok;

  // search over one group of match bits
  logic [GRP_SIZE-1:0] grp_bits;
  logic                grp_hit;
  logic [GSEL_W-1:0]   k_sel;
  logic                last_grp;
  logic [CMP_W-1:0]    hit_pos;

  // result register load
  logic                load_op;
  logic                load_scan;
  logic [CMP_W-1:0]    len_ext;

  assign out_free = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(func);
  assign cnt_ext  = CMP_W'(count);
  assign pos_ext  = CMP_W'(position);

  // insert needs room and a position no further than the end
  assign ins_ok = (cnt_ext < CMP_W'(CAPACITY)) && (pos_ext <= cnt_ext);
  // delete needs a live position
  assign del_ok = (count != '0) && (pos_ext < cnt_ext);

  always_comb begin
    ctrl.ins   = in_fire && (op == OP_INSERT) && ins_ok;
    ctrl.del   = in_fire && (op == OP_DELETE) && del_ok;
    ctrl.clr   = in_fire && (op == OP_CLEAR);
    ctrl.value = value;
    ctrl.pos   = pos_ext;
    ctrl.cnt   = cnt_ext;
  end

  // row of cells, each fed by its neighbors for the shifts
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = ent[i+1];
    end
    sle_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_d),
      .right (right_d),
      .entry (ent[i]),
      .match (match_bits[i])
    );
  end

  // length after the transaction
  always_comb begin
    count_next = count;
    if (ctrl.clr) begin
      count_next = '0;
    end else if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  // first set bit of the current group
  assign grp_bits = hit_vec[grp*GRP_SIZE +: GRP_SIZE];
  always_comb begin
    grp_hit = 1'b0;
    k_sel   = '0;
    for (int k = GRP_SIZE - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        grp_hit = 1'b1;
        k_sel   = GSEL_W'(k);
      end
    end
  end
  assign last_grp = (grp == GW'(NGRP - 1));
  assign hit_pos  = CMP_W'({grp, k_sel});

  // control state machine
  always_comb begin
    state_next = state;
    grp_next   = grp;
    in_ready   = 1'b0;
    load_op    = 1'b0;
    load_scan  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (op == OP_LOCATE) begin
            state_next = S_SCAN;
            grp_next   = '0;
          end else begin
            load_op = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (grp_hit || last_grp) begin
          // hold the group until the result register is free
          if (out_free) begin
            load_scan  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          grp_next = grp + GW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      grp   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      grp   <= grp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && op == OP_LOCATE) begin
      hit_vec <= PADW'(match_bits);
    end
  end

  // result register
  assign len_ext = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_op || load_scan) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_op) begin
      status         <= !(ctrl.ins || ctrl.del || ctrl.clr);
      found          <= 1'b0;
      found_position <= '0;
      length         <= len_ext[LEN_W-1:0];
      is_empty       <= (count_next == '0);
    end else if (load_scan) begin
      status         <= 1'b0;
      found          <= grp_hit;
      found_position <= grp_hit ? hit_pos[FPOS_W-1:0] : '0;
      length         <= len_ext[LEN_W-1:0];
      is_empty       <= (count == '0);
    end
  end

endmodule

// ===== rtl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell
// one list entry: takes from a neighbor on shifts and compares for locate
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] IDX_C1 = CMP_W'(IDX + 1);

  logic [DATA_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.clr) begin
      entry_next = '0;
    end else if (ctrl.ins) begin
      if (IDX_C == ctrl.pos) begin
        entry_next = ctrl.value;
      end else if (IDX_C > ctrl.pos && IDX_C <= ctrl.cnt) begin
        entry_next = left;
      end
    end else if (ctrl.del) begin
      if (IDX_C >= ctrl.pos && IDX_C1 < ctrl.cnt) begin
        entry_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // only live entries can match
  assign match = (entry == ctrl.value) && (IDX_C < ctrl.cnt);

endmodule
